### rtl/itda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itda_pkg
// Shared types, constants and helpers for the integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package itda_pkg;

    localparam int WORD_W  = 32;           // width of the binary operand
    localparam int DIGITS  = 10;           // decimal digits needed for 32 bits
    localparam int DIGIT_W = 4;            // one BCD digit
    localparam int BCD_W   = DIGITS * DIGIT_W;
    localparam int CHAR_W  = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    localparam logic OP_SIGNED   = 1'b0;
    localparam logic OP_UNSIGNED = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } t_state;

    // Status handed from the converter to the sequencer and the emitter.
    typedef struct packed {
        logic done;
        logic neg;
    } t_conv_status;

    // Double-dabble correction: a digit of five or more gets three added
    // before the next shift so that it carries correctly into the next digit.
    function automatic logic [DIGIT_W-1:0] add3(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] r;
        r = (d >= 4'd5) ? d + 4'd3 : d;
        return r;
    endfunction

endpackage

### rtl/itda_dabble.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itda_dabble
// Bit-serial binary to BCD converter: one magnitude bit per cycle.
// ----------------------------------------------------------------------------
module itda_dabble (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [itda_pkg::WORD_W-1:0]  i_value,
    input  logic                         i_opcode,
    output itda_pkg::t_conv_status       o_status,
    output logic [itda_pkg::BCD_W-1:0]   o_bcd
);

    localparam int CNT_W = $clog2(itda_pkg::WORD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(itda_pkg::WORD_W - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_neg;
    logic [itda_pkg::WORD_W-1:0] r_mag;
    logic [itda_pkg::BCD_W-1:0]  r_bcd;

    logic                        n_neg;
    logic [itda_pkg::WORD_W-1:0] n_mag;
    logic [itda_pkg::BCD_W-1:0]  adj;
    logic [itda_pkg::BCD_W-1:0]  n_bcd;

    always_comb begin
        n_neg = (i_opcode == itda_pkg::OP_SIGNED) && i_value[itda_pkg::WORD_W-1];
        n_mag = n_neg ? (itda_pkg::WORD_W'(0) - i_value) : i_value;
    end

    always_comb begin
        for (int i = 0; i < itda_pkg::DIGITS; i++) begin
            adj[i*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W] =
                itda_pkg::add3(r_bcd[i*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W]);
        end
        n_bcd = {adj[itda_pkg::BCD_W-2:0], r_mag[itda_pkg::WORD_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= n_neg;
            r_mag <= n_mag;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bcd <= n_bcd;
            r_mag <= {r_mag[itda_pkg::WORD_W-2:0], 1'b0};
        end
    end

    assign o_status.done = r_done;
    assign o_status.neg  = r_neg;
    assign o_bcd         = r_bcd;

endmodule

### rtl/itda_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itda_emit
// Digit shifter: drops leading zeros; one ASCII char a cycle unless stalled.
// ----------------------------------------------------------------------------
module itda_emit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  itda_pkg::t_conv_status       i_status,
    input  logic [itda_pkg::BCD_W-1:0]   i_bcd,
    input  logic                         i_tready,
    output logic                         o_tvalid,
    output logic [itda_pkg::CHAR_W-1:0]  o_tdata,
    output logic                         o_tlast,
    output logic                         o_active
);

    localparam int CNT_W = $clog2(itda_pkg::DIGITS + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(itda_pkg::DIGITS);

    logic                        r_active;
    logic                        r_sign;
    logic                        r_lead;
    logic [CNT_W-1:0]            r_cnt;
    logic [itda_pkg::BCD_W-1:0]  r_bcd;
    logic                        r_tvalid;
    logic [itda_pkg::CHAR_W-1:0] r_tdata;
    logic                        r_tlast;

    logic [itda_pkg::DIGIT_W-1:0] top_digit;
    logic                         slot_free;
    logic                         skip;
    logic                         send_sign;
    logic                         send_digit;

    always_comb begin
        top_digit  = r_bcd[itda_pkg::BCD_W-1 -: itda_pkg::DIGIT_W];
        slot_free  = !r_tvalid || i_tready;
        // A zero is dropped without using the output slot only while no digit
        // has been sent yet; the lowest digit always goes out, so zero still
        // gives one character.
        skip       = r_active && r_lead && (top_digit == '0) && (r_cnt != CNT_W'(1));
        send_sign  = r_active && r_sign && slot_free;
        send_digit = r_active && !r_sign && !skip && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_sign   <= 1'b0;
            r_tvalid <= 1'b0;
        end else begin
            if (i_status.done) begin
                r_active <= 1'b1;
                r_sign   <= i_status.neg;
            end else begin
                if (send_sign) begin
                    r_sign <= 1'b0;
                end
                if (send_digit && (r_cnt == CNT_W'(1))) begin
                    r_active <= 1'b0;
                end
            end
            if (slot_free) begin
                r_tvalid <= send_sign || send_digit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_status.done) begin
            r_bcd  <= i_bcd;
            r_cnt  <= FULL_CNT;
            r_lead <= 1'b1;
        end else if (skip || send_digit) begin
            r_bcd <= {r_bcd[itda_pkg::BCD_W-itda_pkg::DIGIT_W-1:0],
                      {itda_pkg::DIGIT_W{1'b0}}};
            r_cnt <= r_cnt - 1'b1;
            if (send_digit) begin
                r_lead <= 1'b0;
            end
        end
        if (send_sign) begin
            r_tdata <= itda_pkg::ASCII_MINUS;
            r_tlast <= 1'b0;
        end else if (send_digit) begin
            r_tdata <= itda_pkg::ASCII_ZERO
                       + {{(itda_pkg::CHAR_W-itda_pkg::DIGIT_W){1'b0}}, top_digit};
            r_tlast <= (r_cnt == CNT_W'(1));
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;
    assign o_active = r_active;

endmodule

### rtl/int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Converts a 32-bit word to its decimal ASCII text, one character per word.
// ----------------------------------------------------------------------------
// One input word carries a 32-bit value in tdata and the conversion kind in
// tuser (0 reads the value as two's complement, 1 as unsigned). The block
// answers with the decimal text, most significant character first, one
// character per output word, with tlast on the final digit: a negative signed
// value is preceded by '-', leading zeros are dropped and zero gives a single
// '0'. The conversion is bit-serial double dabble, one operand bit per cycle;
// when the converter is through, the digits are loaded into the digit
// shifter. The shifter then steps through the ten digit positions, dropping
// a leading zero or sending a digit; while the output is not stalled, the
// minus sign is sent in the same cycle as the first dropped zero. Only a
// ten-digit negative number has no zero to drop, so its minus sign is sent
// on its own before the first digit. The shifter goes idle as its last
// character enters the output register, and the sequencer then returns to
// idle and is ready for a new word, so the block takes one item at a time.
// A stalled output holds back the sign and the digits, while leading zeros
// are still dropped.
module int_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [0:0]  i_s_axis_tuser,   // [0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] character
    output logic        o_m_axis_tlast    // last
);

    itda_pkg::t_state r_state;
    itda_pkg::t_state n_state;

    itda_pkg::t_conv_status      conv_status;
    logic [itda_pkg::BCD_W-1:0]  conv_bcd;
    logic                        emit_active;
    logic                        in_ready;
    logic                        in_accept;

    // Sequencer: idle until a word arrives, wait for the converter, then wait
    // for the shifter to hand its last character to the output register.
    always_comb begin
        n_state = r_state;
        case (r_state)
            itda_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = itda_pkg::ST_CONVERT;
                end
            end
            itda_pkg::ST_CONVERT: begin
                if (conv_status.done) begin
                    n_state = itda_pkg::ST_EMIT;
                end
            end
            itda_pkg::ST_EMIT: begin
                if (!emit_active) begin
                    n_state = itda_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = itda_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            itda_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_accept = i_s_axis_tvalid && in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itda_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    itda_dabble u_dabble (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_accept),
        .i_value  (i_s_axis_tdata),
        .i_opcode (i_s_axis_tuser[0]),
        .o_status (conv_status),
        .o_bcd    (conv_bcd)
    );

    itda_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (conv_status),
        .i_bcd    (conv_bcd),
        .i_tready (i_m_axis_tready),
        .o_tvalid (o_m_axis_tvalid),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast),
        .o_active (emit_active)
    );

    assign o_s_axis_tready = in_ready;

    // The converter only finishes while the sequencer is waiting for it.
    a_done_in_convert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv_status.done |-> (r_state == itda_pkg::ST_CONVERT))
        else $error("converter finished outside the convert state");

    // An accepted word always starts a conversion.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state == itda_pkg::ST_CONVERT))
        else $error("accepted word did not start a conversion");

    // The final character of a number is always a digit.
    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |->
            ((o_m_axis_tdata >= itda_pkg::ASCII_ZERO) &&
             (o_m_axis_tdata <= itda_pkg::ASCII_NINE)))
        else $error("last character is not a digit");

    // The shifter is never busy while the block is ready for a new word.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !emit_active)
        else $error("shifter still active while accepting input");

endmodule
